/* hw/rtl/srfc_pkg.sv */
`default_nettype none

package srfc_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 128;

  // Item kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_POLL = 1'b1;

  // Register indexes
  localparam logic REG_IDLE_LIMIT = 1'b0;
  localparam logic REG_WAKE_BYTE  = 1'b1;

  localparam logic [7:0] IDLE_LIMIT_RST = 8'd2;
  localparam logic [7:0] WAKE_BYTE_RST  = 8'h55;

  // Frame layout
  localparam logic [7:0] HDR0          = 8'hEF;
  localparam logic [7:0] HDR1          = 8'h01;
  localparam logic [8:0] LEN_BASE      = 9'd9;
  localparam logic [7:0] PID_FRAME_LEN = 8'd16;
  localparam logic [7:0] POS_HEAD0     = 8'd0;
  localparam logic [7:0] POS_HEAD1     = 8'd1;
  localparam logic [7:0] POS_LENGTH    = 8'd8;
  localparam logic [7:0] POS_CODE      = 8'd9;
  localparam logic [7:0] POS_PAGE      = 8'd11;
  localparam logic [7:0] SUM_START     = 8'd6;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       expect_wake;
  } item_t;

  typedef struct packed {
    logic       answered;
    logic [7:0] code;
    logic [7:0] page_id;
    logic       page_id_valid;
  } result_t;

  typedef struct packed {
    logic [7:0] idle_limit;
    logic [7:0] wake_byte;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/srfc_if.sv */
`default_nettype none

interface srfc_item_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic       expect_wake;

  modport source (output valid, output cmd, output rx_byte, output expect_wake, input ready);
  modport sink   (input valid, input cmd, input rx_byte, input expect_wake, output ready);
endinterface

interface srfc_result_if;
  logic       valid;
  logic       ready;
  logic       answered;
  logic [7:0] code;
  logic [7:0] page_id;
  logic       page_id_valid;

  modport source (output valid, output answered, output code, output page_id,
                  output page_id_valid, input ready);
  modport sink   (input valid, input answered, input code, input page_id,
                  input page_id_valid, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sensor_reply_frame_checker.sv */
// channel     dir  transaction payload
// item_in     in   cmd, rx_byte, expect_wake
// result_out  out  answered, code, page_id, page_id_valid
// cfg_*       in   cfg_index, cfg_wdata (write only, cfg_we strobe)
//
// One item per cycle while no result stalls; a poll's result passes the input register,
// then the result register, set by the single state update pass.
// rst is synchronous: clears both stage valids and the frame state; cfg regs reset to defaults.
// A result held on result_out stalls the update pass; one further item waits
// in the input register, then item_in.ready drops.

`default_nettype none

module sensor_reply_frame_checker
  import srfc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  srfc_item_if.sink       item_in,
  srfc_result_if.source   result_out,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    out_valid;
  result_t out_res;
  result_t res;
  logic    hit;
  logic    stall;
  logic    fire;

  assign stall         = out_valid && !result_out.ready;
  assign fire          = in_valid && !stall;
  assign item_in.ready = !in_valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_item.cmd         <= item_in.cmd;
      in_item.rx_byte     <= item_in.rx_byte;
      in_item.expect_wake <= item_in.expect_wake;
    end
  end

  srfc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  srfc_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .fire (fire),
    .hit  (hit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && hit) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      out_res <= res;
    end
  end

  assign result_out.valid         = out_valid;
  assign result_out.answered      = out_res.answered;
  assign result_out.code          = out_res.code;
  assign result_out.page_id       = out_res.page_id;
  assign result_out.page_id_valid = out_res.page_id_valid;

endmodule

`default_nettype wire

/* hw/rtl/srfc_cfg_regs.sv */
`default_nettype none

module srfc_cfg_regs
  import srfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata,
  output cfg_t            cfg
);

  logic [7:0] idle_limit;
  logic [7:0] wake_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_limit <= IDLE_LIMIT_RST;
      wake_byte  <= WAKE_BYTE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IDLE_LIMIT: idle_limit <= cfg_wdata;
        REG_WAKE_BYTE:  wake_byte  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  assign cfg.idle_limit = idle_limit;
  assign cfg.wake_byte  = wake_byte;

endmodule

`default_nettype wire

/* hw/rtl/srfc_core.sv */
`default_nettype none

module srfc_core
  import srfc_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire item_t item,
  input  wire logic  fire,
  output logic       hit,
  output result_t    res
);

  localparam logic [7:0] CAPACITY = BUFFER_BYTES[7:0];

  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  last_seen_count, last_seen_count_next;
  logic [7:0]  idle_polls, idle_polls_next;
  logic [7:0]  head_byte0, head_byte0_next;
  logic [7:0]  head_byte1, head_byte1_next;
  logic [7:0]  length_byte, length_byte_next;
  logic [7:0]  code_byte, code_byte_next;
  logic [7:0]  page_byte, page_byte_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  prev_byte, prev_byte_next;
  logic [7:0]  newest_byte, newest_byte_next;

  always_comb begin
    logic [7:0]  idle_inc;
    logic [15:0] body;
    logic        pid_ok;

    byte_count_next      = byte_count;
    last_seen_count_next = last_seen_count;
    idle_polls_next      = idle_polls;
    head_byte0_next      = head_byte0;
    head_byte1_next      = head_byte1;
    length_byte_next     = length_byte;
    code_byte_next       = code_byte;
    page_byte_next       = page_byte;
    running_sum_next     = running_sum;
    prev_byte_next       = prev_byte;
    newest_byte_next     = newest_byte;
    hit                  = 1'b0;
    res.answered         = 1'b1;
    res.code             = 8'd0;
    res.page_id          = 8'd0;
    res.page_id_valid    = 1'b0;
    idle_inc             = idle_polls + 8'd1;
    body                 = running_sum - {8'd0, prev_byte} - {8'd0, newest_byte};
    pid_ok               = (byte_count == PID_FRAME_LEN);

    if (item.cmd == CMD_BYTE) begin
      if (byte_count < CAPACITY) begin
        if (byte_count == POS_HEAD0)  head_byte0_next  = item.rx_byte;
        if (byte_count == POS_HEAD1)  head_byte1_next  = item.rx_byte;
        if (byte_count == POS_LENGTH) length_byte_next = item.rx_byte;
        if (byte_count == POS_CODE)   code_byte_next   = item.rx_byte;
        if (byte_count == POS_PAGE)   page_byte_next   = item.rx_byte;
        if (byte_count >= SUM_START)
          running_sum_next = running_sum + {8'd0, item.rx_byte};
        prev_byte_next   = newest_byte;
        newest_byte_next = item.rx_byte;
        byte_count_next  = byte_count + 8'd1;
      end
    end else begin
      // idle supervision first, then the mode check sees the updated count
      if (last_seen_count != byte_count) begin
        idle_polls_next      = 8'd0;
        last_seen_count_next = byte_count;
      end else if (idle_inc > cfg.idle_limit) begin
        idle_polls_next  = 8'd0;
        byte_count_next  = 8'd0;
        running_sum_next = 16'd0;
      end else begin
        idle_polls_next = idle_inc;
      end

      if (item.expect_wake) begin
        if (byte_count_next != 8'd0) begin
          byte_count_next  = 8'd0;
          running_sum_next = 16'd0;
          hit              = (head_byte0 == cfg.wake_byte);
        end
      end else if ({1'b0, byte_count_next} == LEN_BASE + {1'b0, length_byte}) begin
        hit = (head_byte0 == HDR0) && (head_byte1 == HDR1) &&
              (body == {prev_byte, newest_byte});
        res.code          = code_byte;
        res.page_id       = pid_ok ? page_byte : 8'd0;
        res.page_id_valid = pid_ok;
        byte_count_next   = 8'd0;
        running_sum_next  = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= 8'd0;
      last_seen_count <= 8'd0;
      idle_polls      <= 8'd0;
      head_byte0      <= 8'd0;
      head_byte1      <= 8'd0;
      length_byte     <= 8'd0;
      code_byte       <= 8'd0;
      page_byte       <= 8'd0;
      running_sum     <= 16'd0;
      prev_byte       <= 8'd0;
      newest_byte     <= 8'd0;
    end else if (fire) begin
      byte_count      <= byte_count_next;
      last_seen_count <= last_seen_count_next;
      idle_polls      <= idle_polls_next;
      head_byte0      <= head_byte0_next;
      head_byte1      <= head_byte1_next;
      length_byte     <= length_byte_next;
      code_byte       <= code_byte_next;
      page_byte       <= page_byte_next;
      running_sum     <= running_sum_next;
      prev_byte       <= prev_byte_next;
      newest_byte     <= newest_byte_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/srfc_checker.sv */
`default_nettype none

module srfc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       answered,
  input wire logic [7:0] code,
  input wire logic [7:0] page_id,
  input wire logic       page_id_valid
);

  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  a_answered : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> answered)
    else $error("result offered without answered set");

  a_page_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !page_id_valid) |-> (page_id == 8'd0))
    else $error("page id not zero on a result without page id");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(code) && $stable(page_id) && $stable(page_id_valid)))
    else $error("stalled result changed");

endmodule

bind sensor_reply_frame_checker srfc_checker u_srfc_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_out.valid),
  .out_ready     (result_out.ready),
  .answered      (result_out.answered),
  .code          (result_out.code),
  .page_id       (result_out.page_id),
  .page_id_valid (result_out.page_id_valid)
);

`default_nettype wire

/* bench/sensor_reply_frame_checker_tb.sv */
module sensor_reply_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srfc_pkg::*;

  // Mirrors the frame checker: keeps the receive state, works out each poll's reply
  // and holds the replies still owed by the block.
  class reply_tracker;
    bit [7:0]  idle_limit;
    bit [7:0]  wake_byte;
    bit [7:0]  count, seen_count, idle_polls;
    bit [7:0]  head0, head1, len_b, code_b, page_b, prev_b, newest_b;
    bit [15:0] sum;
    result_t   replies_due[$];
    int        faults, checked, frame_hits, wake_hits, page_hits;

    function new();
      idle_limit = IDLE_LIMIT_RST;
      wake_byte  = WAKE_BYTE_RST;
    endfunction

    function void set_reg(logic idx, bit [7:0] v);
      if (idx == REG_IDLE_LIMIT) idle_limit = v;
      else wake_byte = v;
    endfunction

    function void drop_rx();
      count = 0;
      sum   = 0;
    endfunction

    function void predict_reply(item_t it);
      bit [15:0] body;
      bit        ok;
      bit        pid;
      result_t   r;
      if (it.cmd == CMD_BYTE) begin
        // bytes past capacity leave no trace
        if (count < BUFFER_BYTES_DEF) begin
          case (count)
            POS_HEAD0:  head0  = it.rx_byte;
            POS_HEAD1:  head1  = it.rx_byte;
            POS_LENGTH: len_b  = it.rx_byte;
            POS_CODE:   code_b = it.rx_byte;
            POS_PAGE:   page_b = it.rx_byte;
            default: ;
          endcase
          if (count >= SUM_START) sum = sum + it.rx_byte;
          prev_b   = newest_b;
          newest_b = it.rx_byte;
          count++;
        end
        return;
      end
      if (seen_count != count) begin
        idle_polls = 0;
        seen_count = count;
      end else begin
        idle_polls++;
        if (idle_polls > idle_limit) begin
          idle_polls = 0;
          drop_rx();
        end
      end
      r.answered      = 1'b1;
      r.code          = 8'h00;
      r.page_id       = 8'h00;
      r.page_id_valid = 1'b0;
      if (it.expect_wake) begin
        if (count != 0) begin
          drop_rx();
          if (head0 == wake_byte) begin
            replies_due.push_back(r);
            wake_hits++;
          end
        end
        return;
      end
      if ({1'b0, count} == LEN_BASE + {1'b0, len_b}) begin
        pid  = (count == PID_FRAME_LEN);
        body = sum - prev_b - newest_b;
        ok   = (head0 == HDR0) && (head1 == HDR1) && (body == {prev_b, newest_b});
        drop_rx();
        if (ok) begin
          r.code          = code_b;
          r.page_id       = pid ? page_b : 8'h00;
          r.page_id_valid = pid;
          replies_due.push_back(r);
          frame_hits++;
          if (pid) page_hits++;
        end
      end
    endfunction

    function string show(result_t r);
      return $sformatf("answered=%0d code=%02h page_id=%02h page_id_valid=%0d",
                       r.answered, r.code, r.page_id, r.page_id_valid);
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= 10) $display("%0t ns  %s", $time, what);
    endfunction

    function void check_reply(result_t got);
      result_t want;
      if (replies_due.size() == 0) begin
        fault({"reply with none due: ", show(got)});
        return;
      end
      want = replies_due.pop_front();
      checked++;
      if (got !== want) fault({"reply mismatch: expected ", show(want), ", got ", show(got)});
    endfunction

    function void close_out();
      int n;
      n = replies_due.size();
      if (n > 0) begin
        fault($sformatf("%0d replies never came, oldest: %s", n, show(replies_due[0])));
        faults += n - 1;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;

  srfc_item_if   item_bus ();
  srfc_result_if result_bus ();

  sensor_reply_frame_checker u_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_bus),
    .result_out (result_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  reply_tracker tracker;
  int           items_sent;
  int           burst_left;
  int           holds_done;
  bit           steady;
  bit           hold_req;
  bit [7:0]     frame_buf[0:255];
  int           frame_n;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("sensor_reply_frame_checker_tb: done, errors");
    $finish;
  end

  // Receiver: own stall pattern, plus a long hold-off on request.
  initial begin : receiver
    int       style;
    int       style_left;
    int       hold_left;
    bit [7:0] pat;
    result_bus.ready = 1'b0;
    style_left = 0;
    hold_left  = 0;
    pat        = 8'b1011_0010;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        holds_done++;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(16, 96);
      end
      style_left--;
      pat = {pat[6:0], pat[7]};
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready = 1'b0;
      end else begin
        case (style)
          0: result_bus.ready = 1'b1;
          1: result_bus.ready = pat[0];
          default: result_bus.ready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      tracker.check_reply({result_bus.answered, result_bus.code, result_bus.page_id,
                           result_bus.page_id_valid});
  end

  // Sender works in bursts; the transaction is taken at the edge where ready is seen high.
  task automatic offer(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        @(negedge clk);
        item_bus.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    item_bus.valid       = 1'b1;
    item_bus.cmd         = it.cmd;
    item_bus.rx_byte     = it.rx_byte;
    item_bus.expect_wake = it.expect_wake;
    do @(posedge clk); while (!item_bus.ready);
    tracker.predict_reply(it);
    items_sent++;
  endtask

  task automatic send_byte(input bit [7:0] b);
    item_t it;
    it.cmd         = CMD_BYTE;
    it.rx_byte     = b;
    it.expect_wake = 1'($urandom_range(0, 1));
    offer(it);
  endtask

  task automatic send_poll(input bit wake);
    item_t it;
    it.cmd         = CMD_POLL;
    it.rx_byte     = 8'($urandom_range(0, 255));
    it.expect_wake = wake;
    offer(it);
  endtask

  // Well-formed reply frame: header, length, code, checksum over position 6 onward.
  // Lengths 0 and 1 put the checksum over the length byte, so those are solved by hand.
  task automatic make_frame(input int len, input bit [7:0] code);
    bit [15:0] s;
    int        b6;
    int        b7;
    frame_n = 9 + len;
    for (int i = 0; i < frame_n; i++) frame_buf[i] = 8'($urandom_range(0, 255));
    frame_buf[0] = HDR0;
    frame_buf[1] = HDR1;
    frame_buf[8] = 8'(len);
    if (len >= 1) frame_buf[9] = code;
    if (len == 0) begin
      frame_buf[6] = 8'h00;
      frame_buf[7] = 8'h00;
    end else if (len == 1) begin
      b6 = $urandom_range(1, 255);
      b7 = $urandom_range(256 - b6, 255);
      frame_buf[6] = 8'(b6);
      frame_buf[7] = 8'(b7);
      frame_buf[9] = 8'(b6 + b7);
    end else begin
      s = 0;
      for (int i = 6; i < frame_n - 2; i++) s = s + frame_buf[i];
      frame_buf[frame_n - 2] = s[15:8];
      frame_buf[frame_n - 1] = s[7:0];
    end
  endtask

  task automatic push_frame(input bit stray_polls);
    for (int i = 0; i < frame_n; i++) begin
      send_byte(frame_buf[i]);
      if (stray_polls && $urandom_range(0, 99) < 3) send_poll(1'b0);
    end
  endtask

  task automatic random_episode();
    int pick;
    int len;
    int k;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // a wake poll first empties any leftover reception
      send_poll(1'b1);
      k   = $urandom_range(0, 9);
      len = (k < 3) ? 7 : (k < 8) ? $urandom_range(0, 12) : $urandom_range(13, 24);
      make_frame(len, ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
      if (pick >= 55) begin
        if ($urandom_range(0, 3) == 0) frame_buf[$urandom_range(0, 1)] ^= 8'h10;
        else frame_buf[$urandom_range(0, frame_n - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      push_frame(pick < 55);
      send_poll($urandom_range(0, 9) == 0);
    end else if (pick < 80) begin
      send_poll(1'b1);
      send_byte($urandom_range(0, 1) ? tracker.wake_byte : 8'($urandom_range(0, 255)));
      k = $urandom_range(0, 3);
      repeat (k) send_byte(8'($urandom_range(0, 255)));
      send_poll(1'b1);
    end else if (pick < 92) begin
      k = $urandom_range(1, 10);
      repeat (k) begin
        if ($urandom_range(0, 2) == 0) send_poll(1'($urandom_range(0, 1)));
        else send_byte(8'($urandom_range(0, 255)));
      end
    end else begin
      k = $urandom_range(1, 3);
      repeat (k) send_byte(8'($urandom_range(0, 255)));
      k = (tracker.idle_limit <= 4) ? tracker.idle_limit + 2 : $urandom_range(1, 5);
      repeat (k) send_poll(1'b0);
    end
  endtask

  // Registers only change with nothing in flight: drain, then give the pipeline time.
  task automatic settle();
    @(negedge clk);
    item_bus.valid = 1'b0;
    burst_left     = 0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic apply_settings(input bit [7:0] limit_v, input bit [7:0] wake_v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = REG_IDLE_LIMIT;
    cfg_wdata = limit_v;
    @(negedge clk);
    cfg_index = REG_WAKE_BYTE;
    cfg_wdata = wake_v;
    @(negedge clk);
    cfg_we = 1'b0;
    tracker.set_reg(REG_IDLE_LIMIT, limit_v);
    tracker.set_reg(REG_WAKE_BYTE, wake_v);
  endtask

  initial begin : stimulus
    bit [7:0] limits[5];
    bit [7:0] wakes[5];
    int       phase;
    int       phase_end;
    int       ep;
    item_bus.valid       = 1'b0;
    item_bus.cmd         = CMD_BYTE;
    item_bus.rx_byte     = 8'h00;
    item_bus.expect_wake = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_IDLE_LIMIT;
    cfg_wdata  = 8'h00;
    rst        = 1'b1;
    tracker    = new();
    items_sent = 0;
    burst_left = 0;
    holds_done = 0;
    steady     = 1'b1;
    hold_req   = 1'b0;
    limits = '{8'd2, 8'd0, 8'd255, 8'd0, 8'd1};
    wakes  = '{8'h55, 8'hEF, 8'hFF, 8'h00, 8'h00};
    limits[3] = 8'($urandom_range(3, 254));
    wakes[3]  = 8'($urandom_range(1, 254));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    apply_settings(limits[0], wakes[0]);

    // wake poll with nothing received
    send_poll(1'b1);
    // zero-length frame: no byte reaches position 9, so code is the one kept from before
    make_frame(0, 8'h00);
    frame_buf[2] = 8'hFF;
    frame_buf[4] = 8'hFF;
    push_frame(1'b0);
    send_poll(1'b0);
    // wake byte matches
    send_byte(8'h55);
    send_poll(1'b1);
    // stale partial reception dropped after idle_limit quiet polls
    send_byte(8'hFF);
    repeat (4) send_poll(1'b0);
    // wake byte does not match
    send_byte(8'h00);
    send_poll(1'b1);

    for (phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        settle();
        apply_settings(limits[phase], wakes[phase]);
      end
      phase_end = items_sent + 210;
      if (phase == 2) begin
        // idle limit 255: counter wraps, reception is never dropped
        send_poll(1'b1);
        send_byte(8'($urandom_range(0, 255)));
        repeat (258) send_poll(1'b0);
      end else if (phase == 3) begin
        // longer than the buffer: tail bytes dropped, count never reaches the length
        send_poll(1'b1);
        make_frame(120, 8'($urandom_range(0, 255)));
        push_frame(1'b0);
        send_poll(1'b0);
      end
      ep = 0;
      while (items_sent < phase_end) begin
        if (ep % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if (ep == 15 && (phase == 1 || phase == 3)) hold_req = 1'b1;
        random_episode();
        ep++;
      end
    end

    @(negedge clk);
    item_bus.valid = 1'b0;
    while (tracker.replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.close_out();
    $display("summary: %0d transactions in over 5 register settings, %0d replies checked",
             items_sent, tracker.checked);
    $display("summary: %0d frame, %0d wake, %0d with page id, %0d receiver hold-offs",
             tracker.frame_hits, tracker.wake_hits, tracker.page_hits, holds_done);
    if (tracker.faults == 0) begin
      $display("sensor_reply_frame_checker_tb: done, clean");
    end else begin
      $display("sensor_reply_frame_checker_tb: done, errors");
    end
    $finish;
  end

endmodule
